FILE: design/lpht_pkg.sv
// Shared types and constants for the linear-probe hash table unit.
// Depends on nothing; the files that use it refer to it by scoped names.
`default_nettype none

package lpht_pkg;

	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX1   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX2   = 64'h94d049bb133111eb;

	localparam int SPARSITY  = 4;
	localparam int LIMIT_MAX = 2047;
	localparam int OCC_W     = 11;

	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_PUT = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;

	localparam logic [1:0] ST_BLANK  = 2'd0;
	localparam logic [1:0] ST_ACTIVE = 2'd1;
	localparam logic [1:0] ST_TOMB   = 2'd2;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_MISS = 2'd1;
	localparam logic [1:0] STS_FULL = 2'd2;
	localparam logic [1:0] STS_NULL = 2'd3;

	localparam logic [1:0] KIND_WALK  = 2'd0;
	localparam logic [1:0] KIND_NULL  = 2'd1;
	localparam logic [1:0] KIND_BADOP = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  opcode;
		logic [63:0] key;
		logic [31:0] value;
	} job_t;

endpackage

`default_nettype wire

FILE: design/lpht_ifs.sv
// Channel interfaces of the hash table unit: request, response and configuration.
// Depends on nothing.
`default_nettype none

interface lpht_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [63:0] key;
	logic [31:0] value;
	modport source(output valid, output opcode, output key, output value, input ready);
	modport sink(input valid, input opcode, input key, input value, output ready);
endinterface

interface lpht_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] value_out;
	modport source(output valid, output status, output value_out, input ready);
	modport sink(input valid, input status, input value_out, output ready);
endinterface

interface lpht_cfg_if;
	logic        valid;
	logic        ready;
	logic [10:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/lpht_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/lpht_front.sv
// Front end: accepts requests, classifies them and computes the home slot hash.
// Depends on lpht_pkg and lpht_ifs.
`default_nettype none

module lpht_front #(
	parameter int LOG2_CAPACITY = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     hold,
	lpht_req_if.sink                 req,
	output logic                     push,
	output lpht_pkg::job_t           push_job,
	output logic [LOG2_CAPACITY-1:0] push_slot,
	input  logic                     push_ready
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]  state_q;
	logic [1:0]  step_q;
	logic        phase_q;
	lpht_pkg::job_t job_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] p_q;
	logic [LOG2_CAPACITY-1:0] slot_q;

	logic        accept;
	logic [1:0]  new_kind;
	logic [63:0] xa;
	logic [63:0] mix_c;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] prod_sum;
	logic [63:0] hfin;

	assign req.ready = (state_q == F_IDLE) && !hold;
	assign accept    = req.valid && req.ready;

	always_comb begin
		if (req.opcode == lpht_pkg::OP_PUT && req.value == 32'd0) begin
			new_kind = lpht_pkg::KIND_NULL;
		end else if (req.opcode != lpht_pkg::OP_GET && req.opcode != lpht_pkg::OP_PUT &&
			req.opcode != lpht_pkg::OP_DEL) begin
			new_kind = lpht_pkg::KIND_BADOP;
		end else begin
			new_kind = lpht_pkg::KIND_WALK;
		end
	end

	assign xa    = req.key + lpht_pkg::GOLDEN;
	assign mix_c = phase_q ? lpht_pkg::MIX2 : lpht_pkg::MIX1;

	always_comb begin
		case (step_q)
			2'd1: begin
				mul_a = x_q[63:32];
				mul_b = mix_c[31:0];
			end
			2'd2: begin
				mul_a = x_q[31:0];
				mul_b = mix_c[63:32];
			end
			default: begin
				mul_a = x_q[31:0];
				mul_b = mix_c[31:0];
			end
		endcase
	end

	assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
	assign prod_sum = acc_q + {p_q[31:0], 32'd0};
	assign hfin     = prod_sum ^ (prod_sum >> 31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= 2'd0;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= (new_kind == lpht_pkg::KIND_WALK) ? F_MUL : F_PUSH;
						step_q  <= 2'd0;
						phase_q <= 1'b0;
					end
				end
				F_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						phase_q <= ~phase_q;
						if (phase_q) begin
							state_q <= F_PUSH;
						end
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.kind   <= new_kind;
			job_q.opcode <= req.opcode;
			job_q.key    <= req.key;
			job_q.value  <= req.value;
			x_q          <= xa ^ (xa >> 30);
			slot_q       <= '0;
		end
		if (state_q == F_MUL) begin
			p_q <= mul_p;
			case (step_q)
				2'd1: begin
					acc_q <= p_q;
				end
				2'd2: begin
					acc_q <= prod_sum;
				end
				2'd3: begin
					if (!phase_q) begin
						x_q <= prod_sum ^ (prod_sum >> 27);
					end else begin
						slot_q <= hfin[LOG2_CAPACITY-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign push      = (state_q == F_PUSH);
	assign push_job  = job_q;
	assign push_slot = slot_q;

endmodule

`default_nettype wire

FILE: design/lpht_fifo.sv
// Two-entry queue that decouples the front end from the probe engine.
// Depends on nothing.
`default_nettype none

module lpht_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             push_ready,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             valid
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign valid      = (cnt_q != 2'd0);
	assign rdata      = mem_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

FILE: design/lpht_back.sv
// Probe engine: walks the chain, updates the slot stores and drives the response.
// Depends on lpht_pkg, lpht_ifs and lpht_ram.
`default_nettype none

module lpht_back #(
	parameter int LOG2_CAPACITY = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	lpht_cfg_if.sink                 cfg,
	lpht_rsp_if.source               rsp,
	input  logic                     head_valid,
	input  lpht_pkg::job_t           head_job,
	input  logic [LOG2_CAPACITY-1:0] head_slot,
	output logic                     pop,
	output logic                     clearing
);

	localparam int CAP = 1 << LOG2_CAPACITY;
	localparam int LIM_INT = (CAP / lpht_pkg::SPARSITY > lpht_pkg::LIMIT_MAX) ?
		lpht_pkg::LIMIT_MAX : CAP / lpht_pkg::SPARSITY;
	localparam logic [lpht_pkg::OCC_W-1:0] LIM_RST = lpht_pkg::OCC_W'(LIM_INT);

	localparam logic [1:0] B_CLEAR  = 2'd0;
	localparam logic [1:0] B_IDLE   = 2'd1;
	localparam logic [1:0] B_WALK   = 2'd2;
	localparam logic [1:0] B_RETIRE = 2'd3;

	logic [1:0]                 st_q;
	logic [1:0]                 st_d;
	logic [LOG2_CAPACITY-1:0]   clr_q;
	logic [LOG2_CAPACITY-1:0]   k_q;
	logic [LOG2_CAPACITY-1:0]   n_q;
	logic [LOG2_CAPACITY-1:0]   tomb_q;
	logic                       have_tomb_q;
	logic [LOG2_CAPACITY-1:0]   hit_q;
	lpht_pkg::job_t             job_q;
	logic [lpht_pkg::OCC_W-1:0] occ_q;
	logic [lpht_pkg::OCC_W-1:0] limit_q;
	logic                       out_valid_q;
	logic [1:0]                 status_q;
	logic [31:0]                vout_q;

	logic                     out_free;
	logic                     start;
	logic                     step;
	logic                     occ_inc;
	logic                     res_load;
	logic [1:0]               res_status;
	logic [31:0]              res_value;
	logic [LOG2_CAPACITY-1:0] raddr;
	logic [LOG2_CAPACITY-1:0] wa;
	logic [LOG2_CAPACITY-1:0] k_inc;
	logic [LOG2_CAPACITY-1:0] tomb_now;
	logic                     we_st;
	logic                     we_key;
	logic                     we_val;
	logic [1:0]               wd_st;
	logic [31:0]              wd_val;
	logic [1:0]               st_rd;
	logic [63:0]              key_rd;
	logic [31:0]              val_rd;
	logic                     s_blank;
	logic                     s_hit;
	logic                     s_tomb;
	logic                     have_t;
	logic                     last;

	lpht_ram #(.WIDTH(2), .DEPTH(CAP)) u_state_ram (
		.clk(clk), .we(we_st), .waddr(wa), .wdata(wd_st), .raddr(raddr), .rdata(st_rd)
	);
	lpht_ram #(.WIDTH(64), .DEPTH(CAP)) u_key_ram (
		.clk(clk), .we(we_key), .waddr(wa), .wdata(job_q.key), .raddr(raddr), .rdata(key_rd)
	);
	lpht_ram #(.WIDTH(32), .DEPTH(CAP)) u_val_ram (
		.clk(clk), .we(we_val), .waddr(wa), .wdata(wd_val), .raddr(raddr), .rdata(val_rd)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign clearing  = (st_q == B_CLEAR);
	assign k_inc     = k_q + LOG2_CAPACITY'(1);
	assign s_blank   = (st_rd == lpht_pkg::ST_BLANK);
	assign s_hit     = (st_rd == lpht_pkg::ST_ACTIVE) && (key_rd == job_q.key);
	assign s_tomb    = (st_rd == lpht_pkg::ST_TOMB);
	assign have_t    = have_tomb_q || s_tomb;
	assign tomb_now  = have_tomb_q ? tomb_q : k_q;
	assign last      = (n_q == {LOG2_CAPACITY{1'b1}});

	always_comb begin
		st_d       = st_q;
		pop        = 1'b0;
		start      = 1'b0;
		step       = 1'b0;
		occ_inc    = 1'b0;
		res_load   = 1'b0;
		res_status = lpht_pkg::STS_MISS;
		res_value  = 32'd0;
		raddr      = k_inc;
		wa         = k_q;
		we_st      = 1'b0;
		we_key     = 1'b0;
		we_val     = 1'b0;
		wd_st      = lpht_pkg::ST_ACTIVE;
		wd_val     = job_q.value;
		case (st_q)
			B_CLEAR: begin
				we_st = 1'b1;
				wa    = clr_q;
				wd_st = lpht_pkg::ST_BLANK;
				if (clr_q == {LOG2_CAPACITY{1'b1}}) begin
					st_d = B_IDLE;
				end
			end
			B_IDLE: begin
				raddr = head_slot;
				if (head_valid && out_free) begin
					pop = 1'b1;
					if (head_job.kind == lpht_pkg::KIND_WALK) begin
						start = 1'b1;
						st_d  = B_WALK;
					end else begin
						res_load   = 1'b1;
						res_status = (head_job.kind == lpht_pkg::KIND_NULL) ?
							lpht_pkg::STS_NULL : lpht_pkg::STS_MISS;
					end
				end
			end
			B_WALK: begin
				if (!(s_blank || s_hit || last)) begin
					step = 1'b1;
				end else begin
					res_load = 1'b1;
					st_d     = B_IDLE;
					case (job_q.opcode)
						lpht_pkg::OP_GET: begin
							if (s_hit) begin
								res_status = lpht_pkg::STS_OK;
								res_value  = val_rd;
								if (have_t) begin
									wa     = tomb_now;
									we_st  = 1'b1;
									we_key = 1'b1;
									we_val = 1'b1;
									wd_val = val_rd;
									st_d   = B_RETIRE;
								end
							end
						end
						lpht_pkg::OP_PUT: begin
							if (s_hit) begin
								we_val     = 1'b1;
								res_status = lpht_pkg::STS_OK;
							end else if (have_t) begin
								wa         = tomb_now;
								we_st      = 1'b1;
								we_key     = 1'b1;
								we_val     = 1'b1;
								res_status = lpht_pkg::STS_OK;
							end else if (s_blank && occ_q < limit_q) begin
								we_st      = 1'b1;
								we_key     = 1'b1;
								we_val     = 1'b1;
								occ_inc    = 1'b1;
								res_status = lpht_pkg::STS_OK;
							end else begin
								res_status = lpht_pkg::STS_FULL;
							end
						end
						lpht_pkg::OP_DEL: begin
							if (s_hit) begin
								we_st      = 1'b1;
								wd_st      = lpht_pkg::ST_TOMB;
								res_status = lpht_pkg::STS_OK;
							end
						end
						default: begin
							res_status = lpht_pkg::STS_MISS;
						end
					endcase
				end
			end
			B_RETIRE: begin
				we_st = 1'b1;
				wa    = hit_q;
				wd_st = lpht_pkg::ST_TOMB;
				st_d  = B_IDLE;
			end
			default: begin
				st_d = B_IDLE;
			end
		endcase
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_CLEAR;
			clr_q       <= '0;
			k_q         <= '0;
			n_q         <= '0;
			tomb_q      <= '0;
			have_tomb_q <= 1'b0;
			occ_q       <= '0;
			limit_q     <= LIM_RST;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == B_CLEAR) begin
				clr_q <= clr_q + LOG2_CAPACITY'(1);
			end
			if (start) begin
				k_q         <= head_slot;
				n_q         <= '0;
				have_tomb_q <= 1'b0;
			end else if (step) begin
				k_q <= k_inc;
				n_q <= n_q + LOG2_CAPACITY'(1);
				if (s_tomb && !have_tomb_q) begin
					have_tomb_q <= 1'b1;
					tomb_q      <= k_q;
				end
			end
			if (occ_inc) begin
				occ_q <= occ_q + lpht_pkg::OCC_W'(1);
			end
			if (cfg.valid) begin
				limit_q <= cfg.data;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			job_q <= head_job;
		end
		if (st_q == B_WALK) begin
			hit_q <= k_q;
		end
		if (res_load) begin
			status_q <= res_status;
			vout_q   <= res_value;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.value_out = vout_q;

`ifndef SYNTH
	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |-> (occ_q == $past(occ_q) + 1'b1))
		else $error("occupancy count moved by more than one");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_CLEAR) |-> !pop)
		else $error("item taken during clearing pass");
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result overwrote a pending response");
	a_retire_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_RETIRE) |=> (st_q == B_IDLE))
		else $error("retire step not followed by idle");
`endif

endmodule

`default_nettype wire

FILE: design/linear_probe_hash_table_unit.sv
// Top level of the linear-probe hash table unit: front end, queue and probe engine.
// Depends on lpht_pkg, lpht_ifs, lpht_front, lpht_fifo and lpht_back.
// After reset the slot-state memory is swept to blank, one slot a cycle; no request is
// taken during the sweep, while configuration writes are. The front end then takes a
// request only once it has pushed the last one to the queue; it computes the splitmix64
// hash through a single 32x32 multiplier, and a null put or an unused opcode skips the
// hash. The probe engine, decoupled by a two-entry queue, starts a walk and then probes
// one slot per step through the slot memories, with one more step when a get moves its
// entry into a tombstone.
`default_nettype none

module linear_probe_hash_table_unit #(
	parameter int LOG2_CAPACITY = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	lpht_req_if.sink   req,
	lpht_rsp_if.source rsp,
	lpht_cfg_if.sink   cfg
);

	localparam int QW = $bits(lpht_pkg::job_t) + LOG2_CAPACITY;

	logic                     clearing;
	logic                     push;
	logic                     push_ready;
	lpht_pkg::job_t           push_job;
	logic [LOG2_CAPACITY-1:0] push_slot;
	logic [QW-1:0]            q_rdata;
	logic                     q_valid;
	logic                     pop;
	lpht_pkg::job_t           head_job;
	logic [LOG2_CAPACITY-1:0] head_slot;

	lpht_front #(.LOG2_CAPACITY(LOG2_CAPACITY)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.hold(clearing),
		.req(req),
		.push(push),
		.push_job(push_job),
		.push_slot(push_slot),
		.push_ready(push_ready)
	);

	lpht_fifo #(.WIDTH(QW)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata({push_job, push_slot}),
		.push_ready(push_ready),
		.pop(pop),
		.rdata(q_rdata),
		.valid(q_valid)
	);

	assign head_job  = q_rdata[QW-1:LOG2_CAPACITY];
	assign head_slot = q_rdata[LOG2_CAPACITY-1:0];

	lpht_back #(.LOG2_CAPACITY(LOG2_CAPACITY)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.rsp(rsp),
		.head_valid(q_valid),
		.head_job(head_job),
		.head_slot(head_slot),
		.pop(pop),
		.clearing(clearing)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the linear-probe hash table unit: random get, put, delete
// and unused-opcode traffic, checked against a behavioral model of the table held in a scoreboard class.
// Depends on lpht_pkg, lpht_ifs and linear_probe_hash_table_unit.
`default_nettype none

module testbench;

	localparam int CAP = 1024;
	localparam int SLOT_MASK = CAP - 1;
	localparam int TIMEOUT_CYCLES = 2000000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	class hash_table_scoreboard;
		logic [1:0]  slot_st[CAP];
		logic [63:0] slot_k[CAP];
		logic [31:0] slot_v[CAP];
		int          occupied;
		int          limit;
		logic [1:0]  want_status[$];
		logic [31:0] want_value[$];
		int          mismatches;
		int          checked;
		int          hits;
		int          fulls;

		function new();
			for (int i = 0; i < CAP; i++) begin
				slot_st[i] = lpht_pkg::ST_BLANK;
				slot_k[i] = '0;
				slot_v[i] = '0;
			end
			occupied = 0;
			limit = CAP / lpht_pkg::SPARSITY;
			mismatches = 0;
			checked = 0;
			hits = 0;
			fulls = 0;
		endfunction

		function int home_of(logic [63:0] key);
			logic [63:0] x;
			x = key + lpht_pkg::GOLDEN;
			x = (x ^ (x >> 30)) * lpht_pkg::MIX1;
			x = (x ^ (x >> 27)) * lpht_pkg::MIX2;
			x = x ^ (x >> 31);
			return int'(x[9:0]);
		endfunction

		function void note_request(logic [1:0] op, logic [63:0] key, logic [31:0] val);
			int s, tomb, blank, hit;
			bit have_tomb, have_blank, have_hit;
			logic [1:0] st;
			logic [31:0] vout;
			st = lpht_pkg::STS_MISS;
			vout = '0;
			have_tomb = 0;
			have_blank = 0;
			have_hit = 0;
			tomb = 0;
			blank = 0;
			hit = 0;
			if (op == lpht_pkg::OP_PUT && val == 0) begin
				want_status.push_back(lpht_pkg::STS_NULL);
				want_value.push_back('0);
				return;
			end
			s = home_of(key);
			for (int n = 0; n < CAP; n++) begin
				if (slot_st[s] == lpht_pkg::ST_BLANK) begin
					have_blank = 1;
					blank = s;
					break;
				end
				if (slot_st[s] == lpht_pkg::ST_ACTIVE) begin
					if (slot_k[s] == key) begin
						have_hit = 1;
						hit = s;
						break;
					end
				end else if (!have_tomb) begin
					have_tomb = 1;
					tomb = s;
				end
				s = (s + 1) & SLOT_MASK;
			end
			if (op == lpht_pkg::OP_GET) begin
				if (have_hit) begin
					vout = slot_v[hit];
					if (have_tomb) begin
						slot_k[tomb] = slot_k[hit];
						slot_v[tomb] = slot_v[hit];
						slot_st[tomb] = lpht_pkg::ST_ACTIVE;
						slot_st[hit] = lpht_pkg::ST_TOMB;
					end
					st = lpht_pkg::STS_OK;
				end
			end else if (op == lpht_pkg::OP_PUT) begin
				if (have_hit) begin
					slot_v[hit] = val;
					st = lpht_pkg::STS_OK;
				end else if (have_tomb) begin
					slot_k[tomb] = key;
					slot_v[tomb] = val;
					slot_st[tomb] = lpht_pkg::ST_ACTIVE;
					st = lpht_pkg::STS_OK;
				end else if (have_blank && occupied < limit) begin
					slot_k[blank] = key;
					slot_v[blank] = val;
					slot_st[blank] = lpht_pkg::ST_ACTIVE;
					occupied = (occupied + 1) & 11'h7ff;
					st = lpht_pkg::STS_OK;
				end else begin
					st = lpht_pkg::STS_FULL;
				end
			end else if (op == lpht_pkg::OP_DEL) begin
				if (have_hit) begin
					slot_st[hit] = lpht_pkg::ST_TOMB;
					st = lpht_pkg::STS_OK;
				end
			end
			want_status.push_back(st);
			want_value.push_back(vout);
		endfunction

		function void check_response(logic [1:0] st, logic [31:0] vout);
			logic [1:0] es;
			logic [31:0] ev;
			checked++;
			if (want_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: status %0d value %h", st, vout);
				return;
			end
			es = want_status.pop_front();
			ev = want_value.pop_front();
			if (es == lpht_pkg::STS_OK && ev != 0) hits++;
			if (es == lpht_pkg::STS_FULL) fulls++;
			if (st !== es || vout !== ev) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response %0d: expected status %0d value %h, got status %0d value %h",
						checked, es, ev, st, vout);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	lpht_req_if req();
	lpht_rsp_if rsp();
	lpht_cfg_if cfg();

	linear_probe_hash_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	hash_table_scoreboard table_model;
	logic [63:0] key_pool[64];
	int cycles;
	int hold_off;
	int requests_sent;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > TIMEOUT_CYCLES) begin
				$display("timeout after %0d cycles", cycles);
				$display("linear_probe_hash_table_unit test failed");
				$finish;
			end
		end
	end

	// Receiver: stalls on its own pattern, with one long hold-off on request.
	initial begin
		int phase;
		rsp.ready = 0;
		phase = 0;
		forever begin
			@(negedge clk);
			phase++;
			if (hold_off > 0) begin
				hold_off--;
				rsp.ready <= 0;
			end else if ((phase / 200) % 3 == 0) begin
				rsp.ready <= 1;
			end else begin
				rsp.ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && rsp.valid && rsp.ready)
			table_model.check_response(rsp.status, rsp.value_out);

	always @(posedge clk)
		if (arst_n && req.valid && req.ready)
			table_model.note_request(req.opcode, req.key, req.value);

	task automatic write_limit(int lim);
		@(negedge clk);
		cfg.valid <= 1;
		cfg.data <= lim[10:0];
		do @(posedge clk); while (!cfg.ready);
		table_model.limit = lim & 11'h7ff;
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic send_request(logic [1:0] op, logic [63:0] key, logic [31:0] val);
		req.valid <= 1;
		req.opcode <= op;
		req.key <= key;
		req.value <= val;
		do @(posedge clk); while (!req.ready);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		while (table_model.want_status.size() != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_burst(int count, int pool_size);
		int burst;
		logic [1:0] op;
		logic [63:0] key;
		logic [31:0] val;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				req.valid <= 0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				burst = $urandom_range(1, 30);
			end
			burst--;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: op = lpht_pkg::OP_PUT;
				4, 5, 6: op = lpht_pkg::OP_GET;
				7, 8: op = lpht_pkg::OP_DEL;
				default: op = OP_UNUSED;
			endcase
			if ($urandom_range(0, 9) == 0)
				key = {$urandom, $urandom};
			else
				key = key_pool[$urandom_range(0, pool_size - 1)];
			val = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
			send_request(op, key, val);
		end
		req.valid <= 0;
	endtask

	initial begin
		table_model = new();
		hold_off = 0;
		requests_sent = 0;
		req.valid = 0;
		req.opcode = lpht_pkg::OP_GET;
		req.key = '0;
		req.value = '0;
		cfg.valid = 0;
		cfg.data = '0;
		arst_n = 0;
		for (int i = 0; i < 64; i++) key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes of key and value, every opcode, null put, tombstone reuse.
		send_request(lpht_pkg::OP_GET, 64'd0, 32'd0);
		send_request(lpht_pkg::OP_PUT, 64'd0, 32'hffffffff);
		send_request(lpht_pkg::OP_PUT, '1, 32'd1);
		send_request(lpht_pkg::OP_PUT, 64'd5, 32'd0);
		send_request(lpht_pkg::OP_GET, 64'd0, 32'd0);
		send_request(lpht_pkg::OP_GET, '1, 32'd0);
		send_request(lpht_pkg::OP_PUT, 64'd0, 32'h12345678);
		send_request(lpht_pkg::OP_DEL, 64'd0, 32'd0);
		send_request(lpht_pkg::OP_DEL, 64'd0, 32'd0);
		send_request(lpht_pkg::OP_GET, 64'd0, 32'd0);
		send_request(lpht_pkg::OP_PUT, 64'd0, 32'h0badf00d);
		send_request(OP_UNUSED, 64'h5555aaaa5555aaaa, 32'haaaa5555);
		send_request(lpht_pkg::OP_DEL, '1, 32'd0);
		send_request(lpht_pkg::OP_GET, '1, 32'd0);
		req.valid <= 0;
		drain();

		// Tiny limit: table fills at once, then zero limit refuses every new key that finds no tombstone.
		write_limit(2);
		random_burst(150, 8);
		drain();
		write_limit(0);
		random_burst(100, 8);
		drain();

		// Long receiver hold-off while the sender keeps offering beats.
		hold_off = 400;
		write_limit(256);
		random_burst(500, 64);
		drain();

		// Wide limit with big key pool and the field maximum of the register.
		write_limit(2047);
		for (int i = 0; i < 64; i++) key_pool[i] = {$urandom, $urandom};
		random_burst(600, 64);
		drain();
		write_limit(1024);
		random_burst(600, 40);
		drain();

		$display("%0d requests sent, %0d responses checked, %0d get hits, %0d full refusals",
			requests_sent, table_model.checked, table_model.hits, table_model.fulls);
		$display("limits 2, 0, 256, 2047 and 1024 exercised with a long receiver hold-off");
		if (table_model.mismatches == 0 && table_model.want_status.size() == 0)
			$display("linear_probe_hash_table_unit test passed");
		else
			$display("linear_probe_hash_table_unit test failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
design/lpht_pkg.sv
design/lpht_ifs.sv
design/lpht_ram.sv
design/lpht_front.sv
design/lpht_fifo.sv
design/lpht_back.sv
design/linear_probe_hash_table_unit.sv
tb/testbench.sv
